FILE: rtl/dirsp_pkg.sv
// ----------------------------------------------------------------------------
// dirsp_pkg
// Shared widths, register map and defaults of the diagonal seed picker.
// ----------------------------------------------------------------------------
package dirsp_pkg;

  // Field widths
  localparam int unsigned ResW  = 8;   // residue code
  localparam int unsigned QryW  = 31;  // query offsets
  localparam int unsigned SubW  = 40;  // subject offsets
  localparam int unsigned WinW  = 42;  // signed window arithmetic
  localparam int unsigned MidW  = QryW + 2;  // signed midpoint, may dip below zero

  // Configuration port
  localparam int unsigned AddrW = 6;
  localparam int unsigned DataW = 64;

  // Run length that the old start's run must exceed to keep it, default
  localparam int unsigned RUN_LIMIT_DEFAULT = 20;

  // Register indexes (address = 8 * index)
  typedef enum logic [2:0] {
    REG_HIT_QUERY_BEGIN   = 3'd0,
    REG_HIT_QUERY_END     = 3'd1,
    REG_HIT_SUBJECT_BEGIN = 3'd2,
    REG_HIT_SUBJECT_END   = 3'd3,
    REG_OLD_SEED_QUERY    = 3'd4,
    REG_OLD_SEED_SUBJECT  = 3'd5
  } reg_idx_e;

endpackage

FILE: rtl/diagonal_identity_run_seed_picker.sv
// ----------------------------------------------------------------------------
// diagonal_identity_run_seed_picker
// Picks the gapped start point along one diagonal from a stream of residue
// pairs: keeps the old start when its identity run is long enough, else
// moves it to the middle of the first longest run in the scan window, if any.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                 | word
//  ----------+---------------------------+-------------------------------------
//  input     | in_valid_i / in_stall_o   | query/subject residue, query_pos,
//            |                           | last_pair
//  output    | out_valid_o / out_stall_i | seed_moved, seed_query, seed_subject
//  config    | APB psel/penable/pwrite   | six registers, 64-bit data, addr 8*index
//
//  One pair is taken every cycle while in_stall_o is low. Pipeline: input
//  register, match/seed compare, window compare, run-state update, result
//  register, output register. Window bounds are recomputed from the registers
//  in two stages, settled before the first pair reaches the window compare.
//  Reset clears all control and stream state at once; no clearing pass.
//  The whole pipeline freezes only while the result and output registers
//  both hold a word and the output is stalled; in_stall_o follows that.
// ----------------------------------------------------------------------------
module diagonal_identity_run_seed_picker #(
  parameter int unsigned RUN_LIMIT = dirsp_pkg::RUN_LIMIT_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dirsp_pkg::AddrW-1:0]  paddr,
  input  logic [dirsp_pkg::DataW-1:0]  pwdata,
  output logic [dirsp_pkg::DataW-1:0]  prdata,
  output logic                         pready,
  // pair stream
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [dirsp_pkg::ResW-1:0]   query_residue_i,
  input  logic [dirsp_pkg::ResW-1:0]   subject_residue_i,
  input  logic [dirsp_pkg::QryW-1:0]   query_pos_i,
  input  logic                         last_pair_i,
  // result
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         seed_moved_o,
  output logic [dirsp_pkg::QryW-1:0]   seed_query_o,
  output logic [dirsp_pkg::SubW-1:0]   seed_subject_o
);
  import dirsp_pkg::*;

  localparam int unsigned CntW    = $clog2(RUN_LIMIT + 3);
  localparam logic [CntW-1:0] RunSat  = CntW'(RUN_LIMIT + 2);
  localparam logic [CntW-1:0] RunLim  = CntW'(RUN_LIMIT);
  localparam logic [CntW:0]   KeepLim = (CntW + 1)'(RUN_LIMIT + 1);
  localparam logic signed [MidW-1:0] HalfLim = MidW'(RUN_LIMIT / 2);

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v >= RunSat) ? RunSat : v + 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [QryW-1:0] hqb_q, hqe_q, osq_q;
  logic [SubW-1:0] hsb_q, hse_q, oss_q;
  logic            cfg_we;
  reg_idx_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hqb_q <= '0;
      hqe_q <= '0;
      hsb_q <= '0;
      hse_q <= '0;
      osq_q <= '0;
      oss_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_HIT_QUERY_BEGIN:   hqb_q <= pwdata[QryW-1:0];
        REG_HIT_QUERY_END:     hqe_q <= pwdata[QryW-1:0];
        REG_HIT_SUBJECT_BEGIN: hsb_q <= pwdata[SubW-1:0];
        REG_HIT_SUBJECT_END:   hse_q <= pwdata[SubW-1:0];
        REG_OLD_SEED_QUERY:    osq_q <= pwdata[QryW-1:0];
        REG_OLD_SEED_SUBJECT:  oss_q <= pwdata[SubW-1:0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    unique case (cfg_idx)
      REG_HIT_QUERY_BEGIN:   prdata = DataW'(hqb_q);
      REG_HIT_QUERY_END:     prdata = DataW'(hqe_q);
      REG_HIT_SUBJECT_BEGIN: prdata = DataW'(hsb_q);
      REG_HIT_SUBJECT_END:   prdata = DataW'(hse_q);
      REG_OLD_SEED_QUERY:    prdata = DataW'(osq_q);
      REG_OLD_SEED_SUBJECT:  prdata = DataW'(oss_q);
      default:               prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Window bounds, two register stages
  //   start = seed_q - min(seed_s - hsb, seed_q - hqb)
  //   pos < end  <=>  pos < hse + seed_q - seed_s  and  pos < hqe
  // --------------------------------------------------------------------------
  logic signed [WinW-1:0] osq_x, oss_x, hqb_x, hsb_x, hse_x;
  logic signed [WinW-1:0] d1_q, d2_q, x_q, y_q;
  logic signed [WinW-1:0] ws_q, e1_q;
  logic [SubW-1:0]        diag_q;

  assign osq_x = $signed({{(WinW-QryW){1'b0}}, osq_q});
  assign hqb_x = $signed({{(WinW-QryW){1'b0}}, hqb_q});
  assign oss_x = $signed({{(WinW-SubW){1'b0}}, oss_q});
  assign hsb_x = $signed({{(WinW-SubW){1'b0}}, hsb_q});
  assign hse_x = $signed({{(WinW-SubW){1'b0}}, hse_q});

  always_ff @(posedge clk_i) begin
    d1_q   <= oss_x - hsb_x;
    d2_q   <= osq_x - hqb_x;
    x_q    <= hsb_x - oss_x;
    y_q    <= hse_x - oss_x;
    diag_q <= oss_q - SubW'(osq_q);
    ws_q   <= (d1_q < d2_q) ? x_q + osq_x : hqb_x;
    e1_q   <= y_q + osq_x;
  end

  // --------------------------------------------------------------------------
  // Flow control
  // --------------------------------------------------------------------------
  logic adv, o_take, accept;
  logic r_v_q, out_valid_q;

  assign o_take     = !out_valid_q || !out_stall_i;
  assign adv        = !r_v_q || o_take;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Stage A: input register
  // --------------------------------------------------------------------------
  logic            a_v_q, a_last_q;
  logic [ResW-1:0] a_qr_q, a_sr_q;
  logic [QryW-1:0] a_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && accept) begin
      a_qr_q   <= query_residue_i;
      a_sr_q   <= subject_residue_i;
      a_pos_q  <= query_pos_i;
      a_last_q <= last_pair_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: match and seed compares
  // --------------------------------------------------------------------------
  logic            b_v_q, b_m_q, b_last_q, b_seq_q, b_sgt_q, b_ltq_q;
  logic [QryW-1:0] b_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (adv) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_m_q    <= (a_qr_q == a_sr_q);
      b_pos_q  <= a_pos_q;
      b_last_q <= a_last_q;
      b_seq_q  <= (a_pos_q == osq_q);
      b_sgt_q  <= (a_pos_q > osq_q);
      b_ltq_q  <= (a_pos_q < hqe_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: window compares
  // --------------------------------------------------------------------------
  logic                   c_v_q, c_m_q, c_last_q, c_seq_q, c_sgt_q, c_ltq_q;
  logic                   c_win_q, c_wlast_q;
  logic [QryW-1:0]        c_pos_q;
  logic signed [WinW-1:0] b_pos_x, b_pos1_x, hqe_x;

  assign b_pos_x  = $signed({{(WinW-QryW){1'b0}}, b_pos_q});
  assign b_pos1_x = b_pos_x + 1'b1;
  assign hqe_x    = $signed({{(WinW-QryW){1'b0}}, hqe_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (adv) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_m_q     <= b_m_q;
      c_pos_q   <= b_pos_q;
      c_last_q  <= b_last_q;
      c_seq_q   <= b_seq_q;
      c_sgt_q   <= b_sgt_q;
      c_ltq_q   <= b_ltq_q;
      c_win_q   <= (b_pos_x >= ws_q) && (b_pos_x < e1_q) && b_ltq_q;
      c_wlast_q <= (b_pos1_x == e1_q) || (b_pos1_x == hqe_x);
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: run state update
  // --------------------------------------------------------------------------
  logic                   pm_q, pm_n, pm_d;
  logic [CntW-1:0]        rl_q, rl_n, rl_d;
  logic [CntW-1:0]        bl_q, bl_n, bl_d;
  logic signed [MidW-1:0] bm_q, bm_n, bm_d;
  logic [CntW-1:0]        left_q, left_n, left_d;
  logic [CntW-1:0]        right_q, right_n, right_d;
  logic                   open_q, open_n, open_d;
  logic                   sd_q, sd_n, sd_d;
  logic [CntW-1:0]        all_q, all_n, all_d;
  logic                   wc_q, wc_n, wc_d;

  logic                   scan, close1, close2, keep, moved;
  logic [CntW-1:0]        close_len;
  logic signed [MidW-1:0] pos_s, close_at;

  assign pos_s = $signed({{(MidW-QryW){1'b0}}, c_pos_q});

  always_comb begin
    // identity run through the old seed
    all_n   = c_m_q ? sat_inc(all_q) : '0;
    left_n  = left_q;
    right_n = right_q;
    open_n  = open_q;
    if (c_seq_q) begin
      left_n = c_m_q ? all_n : '0;
      if (c_ltq_q && c_m_q) begin
        right_n = CntW'(1);
        open_n  = 1'b1;
      end else begin
        right_n = '0;
        open_n  = 1'b0;
      end
    end else if (open_q && c_sgt_q) begin
      if (c_ltq_q && c_m_q) begin
        right_n = sat_inc(right_q);
      end else begin
        open_n = 1'b0;
      end
    end

    // window scan
    scan   = c_win_q && !sd_q && !wc_q;
    close1 = scan && !c_m_q && pm_q;
    pm_n   = pm_q;
    rl_n   = rl_q;
    sd_n   = sd_q;
    wc_n   = wc_q;
    bl_n   = bl_q;
    bm_n   = bm_q;
    if (scan) begin
      pm_n = c_m_q;
      if (c_m_q && !pm_q) begin
        rl_n = CntW'(1);
      end else if (c_m_q && pm_q) begin
        rl_n = sat_inc(rl_q);
        if (rl_n > RunLim) begin
          sd_n = 1'b1;
          bm_n = pos_s - HalfLim;
        end
      end
      if (!sd_n && c_wlast_q) begin
        wc_n = 1'b1;
      end
    end

    // close the open run: at a falling edge, at window end or stream end
    close2    = pm_n && !sd_n && ((scan && c_wlast_q) || (c_last_q && !wc_n));
    close_len = close1 ? rl_q : rl_n;
    close_at  = close1 ? pos_s : pos_s + 1'b1;
    if ((close1 || close2) && (close_len > bl_n)) begin
      bl_n = close_len;
      bm_n = close_at - $signed(MidW'(close_len >> 1));
    end

    // result test
    keep  = ({1'b0, left_n} + {1'b0, right_n}) > KeepLim;
    moved = !keep && (sd_n || (bl_n != '0));

    // stream state returns to reset after the last pair
    if (c_last_q) begin
      pm_d    = 1'b0;
      rl_d    = '0;
      bl_d    = '0;
      bm_d    = '0;
      left_d  = '0;
      right_d = '0;
      open_d  = 1'b0;
      sd_d    = 1'b0;
      all_d   = '0;
      wc_d    = 1'b0;
    end else begin
      pm_d    = pm_n;
      rl_d    = rl_n;
      bl_d    = bl_n;
      bm_d    = bm_n;
      left_d  = left_n;
      right_d = right_n;
      open_d  = open_n;
      sd_d    = sd_n;
      all_d   = all_n;
      wc_d    = wc_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_q    <= 1'b0;
      rl_q    <= '0;
      bl_q    <= '0;
      bm_q    <= '0;
      left_q  <= '0;
      right_q <= '0;
      open_q  <= 1'b0;
      sd_q    <= 1'b0;
      all_q   <= '0;
      wc_q    <= 1'b0;
    end else if (adv && c_v_q) begin
      pm_q    <= pm_d;
      rl_q    <= rl_d;
      bl_q    <= bl_d;
      bm_q    <= bm_d;
      left_q  <= left_d;
      right_q <= right_d;
      open_q  <= open_d;
      sd_q    <= sd_d;
      all_q   <= all_d;
      wc_q    <= wc_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register (skid stage)
  // --------------------------------------------------------------------------
  logic                   r_moved_q;
  logic signed [MidW-1:0] r_mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v_q <= 1'b0;
    end else if (adv) begin
      r_v_q <= c_v_q && c_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && c_v_q && c_last_q) begin
      r_moved_q <= moved;
      r_mid_q   <= bm_n;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: subject start follows the diagonal
  // --------------------------------------------------------------------------
  logic            seed_moved_q;
  logic [QryW-1:0] seed_query_q;
  logic [SubW-1:0] seed_subject_q;
  logic [SubW-1:0] mid_sub;

  assign mid_sub = {{(SubW-MidW){r_mid_q[MidW-1]}}, r_mid_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (o_take) begin
      out_valid_q <= r_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_take && r_v_q) begin
      seed_moved_q   <= r_moved_q;
      seed_query_q   <= r_moved_q ? r_mid_q[QryW-1:0] : osq_q;
      seed_subject_q <= r_moved_q ? mid_sub + diag_q : oss_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign seed_moved_o   = seed_moved_q;
  assign seed_query_o   = seed_query_q;
  assign seed_subject_o = seed_subject_q;

endmodule

FILE: rtl/dirsp_checker.sv
// ----------------------------------------------------------------------------
// dirsp_checker
// Port-level checks on the seed picker's result channel and back-pressure.
// ----------------------------------------------------------------------------
module dirsp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        seed_moved_o,
  input logic [dirsp_pkg::QryW-1:0]  seed_query_o,
  input logic [dirsp_pkg::SubW-1:0]  seed_subject_o
);

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // and keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(seed_moved_o) && $stable(seed_query_o)
      && $stable(seed_subject_o))
    else $error("result word changed while stalled");

  // input back-pressure only with a word waiting at the output
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // input back-pressure only while the output itself is held off
  a_stall_needs_out_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled while output moves");

endmodule

bind diagonal_identity_run_seed_picker dirsp_checker u_dirsp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .seed_moved_o   (seed_moved_o),
  .seed_query_o   (seed_query_o),
  .seed_subject_o (seed_subject_o)
);

FILE: tb/diagonal_identity_run_seed_picker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// diagonal_identity_run_seed_picker_tb
// Streams residue pairs along one diagonal through the seed picker and checks
// each returned start against an in-bench model of the keep test and the
// longest-run window scan. Register settings change between phases while the
// block is idle; both handshakes idle and stall at random, with one long
// output hold that backs the block up.
// ----------------------------------------------------------------------------
module diagonal_identity_run_seed_picker_tb;
  import dirsp_pkg::*;

  localparam int unsigned RunLimit    = RUN_LIMIT_DEFAULT;
  localparam int          TotalPairs  = 1350;
  localparam int          DrainCycles = 10;
  localparam int          HoldCycles  = 80;
  // ~1400 pairs, each after at worst an idle gap plus stalls, config writes
  // between ~40 phases; taken many times over
  localparam int          CycleLimit  = 300000;
  localparam logic [63:0] QryMask     = 64'h7FFF_FFFF;
  localparam logic [63:0] SubMask     = 64'hFF_FFFF_FFFF;

  typedef struct packed {
    logic              moved;
    logic [QryW-1:0]   qry;
    logic [SubW-1:0]   sub;
  } seed_word_t;

  // Model of the seed picker plus the queue of starts still to come out
  class seed_pick_board;
    logic [QryW-1:0] qry_begin, qry_end, seed_q;
    logic [SubW-1:0] sub_begin, sub_end, seed_s;
    bit     in_run, right_open, done, win_closed;
    int     run_len, best_len, left_run, right_run, lead_run;
    longint best_mid;
    seed_word_t pending_seeds[$];
    int     errors, n_checked, n_moved;

    function new();
      qry_begin = '0; qry_end = '0; seed_q = '0;
      sub_begin = '0; sub_end = '0; seed_s = '0;
      errors = 0; n_checked = 0; n_moved = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      in_run = 0; right_open = 0; done = 0; win_closed = 0;
      run_len = 0; best_len = 0; left_run = 0; right_run = 0; lead_run = 0;
      best_mid = 0;
    endfunction

    function int sat_inc(int v);
      return (v >= RunLimit + 2) ? RunLimit + 2 : v + 1;
    endfunction

    function void close_run(longint at);
      if (in_run && run_len > best_len) begin
        best_len = run_len;
        best_mid = at - longint'(run_len / 2);
      end
    endfunction

    function void set_reg(reg_idx_e idx, logic [63:0] v);
      case (idx)
        REG_HIT_QUERY_BEGIN:   qry_begin = v[QryW-1:0];
        REG_HIT_QUERY_END:     qry_end   = v[QryW-1:0];
        REG_HIT_SUBJECT_BEGIN: sub_begin = v[SubW-1:0];
        REG_HIT_SUBJECT_END:   sub_end   = v[SubW-1:0];
        REG_OLD_SEED_QUERY:    seed_q    = v[QryW-1:0];
        REG_OLD_SEED_SUBJECT:  seed_s    = v[SubW-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_seeds.size();
    endfunction

    // One accepted pair; on the last pair of a stream queue the expected start
    function void note_pair(logic [ResW-1:0] qr, logic [ResW-1:0] sr,
                            logic [QryW-1:0] pos_b, logic last);
      bit         m, keep, moved;
      longint     pos, qgs, sgs, qend, d1, d2, off, ws, ss0, l1, l2, wl, we;
      longint     nq, ns;
      seed_word_t w;
      m    = (qr == sr);
      pos  = pos_b;
      qgs  = seed_q;
      sgs  = seed_s;
      qend = qry_end;
      d1   = sgs - longint'(sub_begin);
      d2   = qgs - longint'(qry_begin);
      off  = (d1 < d2) ? d1 : d2;
      ws   = qgs - off;
      ss0  = sgs - off;
      l1   = longint'(sub_end) - ss0;
      l2   = qend - ws;
      wl   = (l1 < l2) ? l1 : l2;
      we   = ws + wl;

      // identity run through the old start
      lead_run = m ? sat_inc(lead_run) : 0;
      if (pos == qgs) begin
        left_run = m ? lead_run : 0;
        if (pos < qend && m) begin
          right_run = 1; right_open = 1;
        end else begin
          right_run = 0; right_open = 0;
        end
      end else if (right_open && pos > qgs) begin
        if (pos < qend && m) right_run = sat_inc(right_run);
        else right_open = 0;
      end

      // scan window
      if (wl > 0 && pos >= ws && pos < we && !done && !win_closed) begin
        if (m != in_run) begin
          if (!m) close_run(pos);
          in_run = m;
          if (m) run_len = 1;
        end else if (m) begin
          run_len = sat_inc(run_len);
          if (run_len > RunLimit) begin
            done = 1;
            best_mid = pos - longint'(RunLimit / 2);
          end
        end
        if (!done && pos == we - 1) begin
          close_run(we);
          win_closed = 1;
        end
      end

      if (!last) return;
      if (!done && !win_closed) close_run(pos + 1);
      keep  = (left_run + right_run) > RunLimit + 1;
      moved = !keep && (done || best_len > 0);
      nq    = moved ? best_mid : qgs;
      ns    = moved ? nq + (sgs - qgs) : sgs;
      w.moved = moved;
      w.qry   = QryW'(nq);
      w.sub   = SubW'(ns);
      pending_seeds.push_back(w);
      clear_stream();
    endfunction

    function void check_result(logic moved, logic [QryW-1:0] qry, logic [SubW-1:0] sub);
      seed_word_t w;
      if (pending_seeds.size() == 0) begin
        $display("%0t: result with nothing expected: moved %0b query %h subject %h",
                 $time, moved, qry, sub);
        errors++;
        return;
      end
      w = pending_seeds.pop_front();
      n_checked++;
      if (w.moved) n_moved++;
      if (moved !== w.moved) begin
        $display("%0t: seed_moved expected %0b actual %0b", $time, w.moved, moved);
        errors++;
      end
      if (qry !== w.qry) begin
        $display("%0t: seed_query expected %h actual %h", $time, w.qry, qry);
        errors++;
      end
      if (sub !== w.sub) begin
        $display("%0t: seed_subject expected %h actual %h", $time, w.sub, sub);
        errors++;
      end
    endfunction
  endclass

  // Block ports
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [ResW-1:0]   query_residue_i = '0;
  logic [ResW-1:0]   subject_residue_i = '0;
  logic [QryW-1:0]   query_pos_i = '0;
  logic              last_pair_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              seed_moved_o;
  logic [QryW-1:0]   seed_query_o;
  logic [SubW-1:0]   seed_subject_o;

  seed_pick_board board = new();

  // Stimulus bookkeeping
  int              idle_pct = 14;
  int              stall_pct = 14;
  int              hold_token = 0;
  int              hold_seen = 0;
  int              hold_left = 0;
  int              pairs_sent = 0;
  int              streams_sent = 0;
  int              settings_used = 0;
  int              cycles = 0;
  logic [QryW-1:0] seed_q_cur = '0;

  diagonal_identity_run_seed_picker #(
    .RUN_LIMIT(RunLimit)
  ) dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_stall_o,
    .query_residue_i,
    .subject_residue_i,
    .query_pos_i,
    .last_pair_i,
    .out_valid_o,
    .out_stall_i,
    .seed_moved_o,
    .seed_query_o,
    .seed_subject_o
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, board.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: check accepted words, random stalls, long hold on request
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(seed_moved_o, seed_query_o, seed_subject_o);
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_token != hold_seen) begin
      hold_seen   <= hold_token;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // APB write: setup, access, then idle
  task automatic write_reg(input reg_idx_e idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    board.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pair(input logic [ResW-1:0] qr, input logic [ResW-1:0] sr,
                           input logic [QryW-1:0] pos, input logic last);
    in_valid_i        <= 1'b1;
    query_residue_i   <= qr;
    subject_residue_i <= sr;
    query_pos_i       <= pos;
    last_pair_i       <= last;
    do @(posedge clk_i); while (in_stall_o);
    board.note_pair(qr, sr, pos, last);
    pairs_sent++;
  endtask

  task automatic idle_in(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Stop sending and wait for every expected start, plus pipeline slack
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One stream of pairs; scattered streams jump to random positions
  task automatic send_stream(input logic [QryW-1:0] start, input int len,
                             input int match_pct, input bit scattered);
    logic [QryW-1:0] pos;
    logic [ResW-1:0] qr, sr;
    pos = start;
    for (int i = 0; i < len; i++) begin
      qr = ResW'($urandom);
      sr = ($urandom_range(99) < match_pct) ? qr : qr ^ ResW'($urandom_range(1, 255));
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) idle_in($urandom_range(1, 4));
      send_pair(qr, sr, scattered ? QryW'($urandom) : pos, i == len - 1);
      pos = pos + 1'b1;
    end
    streams_sent++;
  endtask

  function automatic int pick_match_pct();
    case ($urandom_range(4))
      0: return 20;
      1: return 60;
      2: return 85;
      3: return 95;
      default: return 100;
    endcase
  endfunction

  task automatic load_setting(input longint qb, input longint qe, input longint sb0,
                              input longint se, input longint sq, input longint ss);
    write_reg(REG_HIT_QUERY_BEGIN,   64'(qb)  & QryMask);
    write_reg(REG_HIT_QUERY_END,     64'(qe)  & QryMask);
    write_reg(REG_HIT_SUBJECT_BEGIN, 64'(sb0) & SubMask);
    write_reg(REG_HIT_SUBJECT_END,   64'(se)  & SubMask);
    write_reg(REG_OLD_SEED_QUERY,    64'(sq)  & QryMask);
    write_reg(REG_OLD_SEED_SUBJECT,  64'(ss)  & SubMask);
    seed_q_cur = QryW'(sq);
    settings_used++;
  endtask

  // mode 0: all zero, 1: all ones, 2: unrelated random values,
  // otherwise a hit with the old start in or just past it, near either end of range
  task automatic pick_setting(input int mode);
    longint qb, qe, sb0, se, sq, ss;
    int     span;
    case (mode)
      0: load_setting(0, 0, 0, 0, 0, 0);
      1: load_setting(64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'hFF_FFFF_FFFF,
                      64'hFF_FFFF_FFFF, 64'h7FFF_FFFF, 64'hFF_FFFF_FFFF);
      2: load_setting($urandom, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                      $urandom, {$urandom, $urandom});
      default: begin
        span = $urandom_range(0, 90);
        qb   = ($urandom_range(9) == 0) ? 64'h7FFF_FFFF - $urandom_range(0, 150)
                                        : longint'($urandom_range(0, 3000));
        qe   = ($urandom_range(9) == 0) ? qb - $urandom_range(1, 10) : qb + span;
        sq   = qb + $urandom_range(0, span + 5);
        sb0  = ($urandom_range(9) == 0) ? 64'hFF_FFFF_FFFF - $urandom_range(0, 150)
                                        : longint'($urandom_range(0, 100000));
        ss   = sb0 + (sq - qb) + $urandom_range(0, 8) - 4;
        se   = sb0 + span + $urandom_range(0, 20) - 10;
        load_setting(qb, qe, sb0, se, sq, ss);
      end
    endcase
  endtask

  initial begin
    int phase;
    int target;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset setting, empty window, seed at zero, residue extremes
    send_pair(8'h00, 8'h00, '0, 1'b1);
    send_pair(8'hFF, 8'h00, '0, 1'b1);
    drain_results();
    // Directed: 22 matches through the seed, long enough to keep it
    load_setting(100, 150, 1000, 1050, 120, 1020);
    for (int i = 110; i < 132; i++)
      send_pair(8'hFF, 8'hFF, QryW'(i), i == 131);
    // top query position, alone in its stream
    send_pair(8'h5A, 8'h5A, '1, 1'b1);
    drain_results();

    // Random phases, each with a fresh register setting
    for (phase = 1; pairs_sent < TotalPairs; phase++) begin
      if (phase == 8) begin
        idle_pct = 0;
        stall_pct <= 0;
      end
      if (phase == 12) begin
        idle_pct = 14;
        stall_pct <= 14;
      end
      if (phase == 1) pick_setting(1);
      else if (phase == 2) pick_setting(0);
      else pick_setting(($urandom_range(9) == 0) ? 2 : 3);

      // long output hold while one-pair streams keep coming
      if (phase == 3) begin
        hold_token <= hold_token + 1;
        repeat (30) send_stream(seed_q_cur - QryW'($urandom_range(0, 20)), 1, 60, 0);
      end

      target = pairs_sent + $urandom_range(20, 60);
      while (pairs_sent < target) begin
        if ($urandom_range(9) == 0)
          send_stream(QryW'($urandom), $urandom_range(1, 12), 30, 1);
        else
          send_stream(seed_q_cur - QryW'($urandom_range(0, 40)), $urandom_range(1, 70),
                      pick_match_pct(), 0);
      end
      drain_results();
    end

    repeat (20) @(posedge clk_i);
    $display("Summary: %0d pairs in %0d streams over %0d register settings",
             pairs_sent, streams_sent, settings_used);
    $display("Summary: %0d starts checked, %0d moved, %0d mismatches",
             board.n_checked, board.n_moved, board.errors);
    if (board.errors == 0 && board.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
